FILE: rtl/fir_pkg.sv
// Shared constants, types and state codes for the FIR convolution filter.
package fir_pkg;

  localparam int TAPS       = 1024;
  localparam int ADDR_W     = $clog2(TAPS);
  localparam int SAMPLE_W   = 16;
  localparam int ACC_W      = 40;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int TCOUNT_W   = 11;
  localparam int SHIFT_W    = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int IN_BITS    = 2 * SAMPLE_W + ADDR_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SAMPLE_W + 7) / 8) * 8;

  localparam logic [TCOUNT_W-1:0] TCOUNT_RST = TCOUNT_W'(TAPS);
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(15);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  localparam logic REG_TAP_COUNT = 1'b0;
  localparam logic REG_OUT_SHIFT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_FINISH
  } fir_state_t;

  typedef struct packed {
    logic clr;
    logic start;
    logic load_coef;
    logic issue;
    logic finish;
  } fir_cmd_t;

  typedef struct packed {
    logic in_op;
    logic clr_last;
    logic k_last;
    logic pipe_busy;
    logic out_free;
  } fir_sts_t;

endpackage

FILE: rtl/fir_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/fir_ctrl.sv
// Controller state machine sequencing memory clearing, tap reads and output loading.
module fir_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  fir_pkg::fir_sts_t sts,
  output fir_pkg::fir_cmd_t cmd
);

  fir_pkg::fir_state_t state_r, state_nxt;
  logic accept;

  assign accept = in_tvalid && (state_r == fir_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fir_pkg::ST_CLEAR: begin
        if (sts.clr_last) state_nxt = fir_pkg::ST_IDLE;
      end
      fir_pkg::ST_IDLE: begin
        if (accept && sts.in_op == fir_pkg::OP_SAMPLE) state_nxt = fir_pkg::ST_MAC;
      end
      fir_pkg::ST_MAC: begin
        if (sts.k_last) state_nxt = fir_pkg::ST_FLUSH;
      end
      fir_pkg::ST_FLUSH: begin
        if (!sts.pipe_busy) state_nxt = fir_pkg::ST_FINISH;
      end
      fir_pkg::ST_FINISH: begin
        if (sts.out_free) state_nxt = fir_pkg::ST_IDLE;
      end
      default: state_nxt = fir_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      fir_pkg::ST_CLEAR: begin
        cmd.clr = 1'b1;
      end
      fir_pkg::ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.start     = accept && sts.in_op == fir_pkg::OP_SAMPLE;
        cmd.load_coef = accept && sts.in_op == fir_pkg::OP_COEF;
      end
      fir_pkg::ST_MAC: begin
        cmd.issue = 1'b1;
      end
      fir_pkg::ST_FLUSH: begin
        cmd = '0;
      end
      fir_pkg::ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_tap_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_pkg::ST_MAC && sts.k_last) |=> state_r == fir_pkg::ST_FLUSH)
    else $error("last tap read did not lead to flush");
  a_finish_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!sts.pipe_busy && sts.out_free))
    else $error("result loaded while pipeline busy or output full");
  a_start_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> state_r == fir_pkg::ST_MAC)
    else $error("accepted sample did not start the tap sweep");
`endif

endmodule

FILE: rtl/fir_dp.sv
// Datapath: configuration registers, delay line and tap memories, MAC pipeline, output stage.
module fir_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fir_pkg::fir_cmd_t                  cmd,
  output fir_pkg::fir_sts_t                  sts,
  input  logic [fir_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                               in_tuser,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fir_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [fir_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [fir_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fir_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tuser
);

  localparam int AW = fir_pkg::ADDR_W;
  localparam int SW = fir_pkg::SAMPLE_W;
  localparam int AC = fir_pkg::ACC_W;
  localparam int PW = fir_pkg::PROD_W;

  logic [fir_pkg::TCOUNT_W-1:0] tcount_r, tcount_nxt;
  logic [fir_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic                         cfg_wr;
  logic                         cfg_idx;

  logic [SW-1:0] sample_in;
  logic [AW-1:0] tap_index;
  logic [SW-1:0] tap_value;

  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] k_r, k_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [AW-1:0] nm1_r, nm1_nxt;
  logic [AW-1:0] nm1_new;
  logic [AW-1:0] ptr_c;
  logic [fir_pkg::TCOUNT_W-1:0] tcount_m1;

  logic          dl_we, cf_we;
  logic [AW-1:0] dl_waddr, cf_waddr;
  logic [SW-1:0] dl_wdata, cf_wdata;
  logic [SW-1:0] dl_q, cf_q;

  logic          rd_v_r, rd_v_nxt;
  logic          prod_v_r, prod_v_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [AC-1:0] acc_r, acc_nxt;

  logic [AC-1:0] shifted;
  logic          ovf;
  logic [SW-1:0] sat_val;

  logic          out_v_r, out_v_nxt;
  logic [SW-1:0] out_d_r, out_d_nxt;
  logic          out_s_r, out_s_nxt;

  assign sample_in = in_tdata[SW-1:0];
  assign tap_index = in_tdata[SW+AW-1:SW];
  assign tap_value = in_tdata[2*SW+AW-1:SW+AW];

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = cfg_paddr[2];

  always_comb begin
    tcount_nxt = tcount_r;
    shift_nxt  = shift_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        fir_pkg::REG_TAP_COUNT: tcount_nxt = cfg_pwdata[fir_pkg::TCOUNT_W-1:0];
        fir_pkg::REG_OUT_SHIFT: shift_nxt  = cfg_pwdata[fir_pkg::SHIFT_W-1:0];
        default: tcount_nxt = tcount_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fir_pkg::REG_TAP_COUNT:
        cfg_prdata = fir_pkg::CFG_DATA_W'(tcount_r);
      fir_pkg::REG_OUT_SHIFT:
        cfg_prdata = fir_pkg::CFG_DATA_W'(shift_r);
      default: cfg_prdata = '0;
    endcase
  end

  // Clamp the tap count into 1..TAPS and keep it as count minus one.
  assign tcount_m1 = tcount_r - fir_pkg::TCOUNT_W'(1);
  always_comb begin
    if (tcount_r == '0) begin
      nm1_new = '0;
    end else if (tcount_r > fir_pkg::TCOUNT_W'(fir_pkg::TAPS)) begin
      nm1_new = AW'(fir_pkg::TAPS - 1);
    end else begin
      nm1_new = tcount_m1[AW-1:0];
    end
  end

  assign ptr_c = (wp_r > nm1_new) ? nm1_new : wp_r;

  always_comb begin
    wp_nxt  = wp_r;
    k_nxt   = k_r;
    j_nxt   = j_r;
    nm1_nxt = nm1_r;
    if (cmd.start) begin
      wp_nxt  = (ptr_c == '0) ? nm1_new : ptr_c - AW'(1);
      k_nxt   = '0;
      j_nxt   = ptr_c;
      nm1_nxt = nm1_new;
    end else if (cmd.clr || cmd.issue) begin
      k_nxt = k_r + AW'(1);
      j_nxt = (j_r == nm1_r) ? '0 : j_r + AW'(1);
    end
  end

  assign dl_we    = cmd.clr || cmd.start;
  assign dl_waddr = cmd.clr ? k_r : ptr_c;
  assign dl_wdata = cmd.clr ? '0 : sample_in;
  assign cf_we    = cmd.clr || cmd.load_coef;
  assign cf_waddr = cmd.clr ? k_r : tap_index;
  assign cf_wdata = cmd.clr ? '0 : tap_value;

  fir_ram #(.WIDTH(SW), .DEPTH(fir_pkg::TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (j_r),
    .rdata (dl_q)
  );

  fir_ram #(.WIDTH(SW), .DEPTH(fir_pkg::TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (cf_waddr),
    .wdata (cf_wdata),
    .raddr (k_r),
    .rdata (cf_q)
  );

  assign rd_v_nxt   = cmd.issue;
  assign prod_v_nxt = rd_v_r;
  assign prod_nxt   = rd_v_r ? PW'($signed(cf_q) * $signed(dl_q)) : prod_r;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.start) begin
      acc_nxt = '0;
    end else if (prod_v_r) begin
      acc_nxt = acc_r + {{(AC-PW){prod_r[PW-1]}}, prod_r};
    end
  end

  assign shifted = $signed(acc_r) >>> shift_r;
  assign ovf     = !((&shifted[AC-1:SW-1]) || !(|shifted[AC-1:SW-1]));
  assign sat_val = shifted[AC-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    out_d_nxt = out_d_r;
    out_s_nxt = out_s_r;
    if (cmd.finish) begin
      out_v_nxt = 1'b1;
      out_d_nxt = ovf ? sat_val : shifted[SW-1:0];
      out_s_nxt = ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tcount_r <= fir_pkg::TCOUNT_RST;
      shift_r  <= fir_pkg::SHIFT_RST;
      wp_r     <= '0;
      k_r      <= '0;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      tcount_r <= tcount_nxt;
      shift_r  <= shift_nxt;
      wp_r     <= wp_nxt;
      k_r      <= k_nxt;
      rd_v_r   <= rd_v_nxt;
      prod_v_r <= prod_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r     <= j_nxt;
    nm1_r   <= nm1_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    out_d_r <= out_d_nxt;
    out_s_r <= out_s_nxt;
  end

  assign sts.in_op     = in_tuser;
  assign sts.clr_last  = (k_r == AW'(fir_pkg::TAPS - 1));
  assign sts.k_last    = (k_r == nm1_r);
  assign sts.pipe_busy = rd_v_r || prod_v_r;
  assign sts.out_free  = !out_v_r || out_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = fir_pkg::OUT_DATA_W'(out_d_r);
  assign out_tuser  = out_s_r;

`ifndef SYNTHESIS
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> ptr_c <= nm1_new)
    else $error("sample written beyond the active tap range");
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> j_r <= nm1_r)
    else $error("delay line read beyond the active tap range");
  a_acc_quiet_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !sts.pipe_busy)
    else $error("new sample started while products still in flight");
`endif

endmodule

FILE: rtl/fir_convolution_filter.sv
// Top level of the FIR convolution filter: controller, datapath and port wiring.
// A coefficient beat is written straight into the coefficient memory; a sample beat runs a
// sweep over its N active taps, and the next beat is taken only after the result is handed
// to the output register, which waits while the output is full (one shared MAC, one tap
// read per cycle from each memory). After reset a clearing pass zeroes all 1024 entries of
// both memories while in_tready stays low; configuration writes are taken throughout.
module fir_convolution_filter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // sample_in [15:0], tap_index [25:16], tap_value [41:26], zero padding above
  input  logic [fir_pkg::IN_DATA_W-1:0]  in_tdata,
  // op
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // filtered [15:0]
  output logic [fir_pkg::OUT_DATA_W-1:0] out_tdata,
  // saturated
  output logic                           out_tuser,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fir_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fir_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fir_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  fir_pkg::fir_cmd_t cmd;
  fir_pkg::fir_sts_t sts;

  assign cfg_pready = 1'b1;

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fir_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

FILE: dv/fir_convolution_filter_test.sv
// Self-checking testbench for the FIR filter: directed and random beats against a predictor.
`timescale 1ns / 100ps

module fir_convolution_filter_test;

  localparam int TAPS       = fir_pkg::TAPS;
  localparam int ADDR_W     = fir_pkg::ADDR_W;
  localparam int SAMPLE_W   = fir_pkg::SAMPLE_W;
  localparam int ACC_W      = fir_pkg::ACC_W;
  localparam int PROD_W     = fir_pkg::PROD_W;
  localparam int TCOUNT_W   = fir_pkg::TCOUNT_W;
  localparam int SHIFT_W    = fir_pkg::SHIFT_W;
  localparam int CFG_DATA_W = fir_pkg::CFG_DATA_W;
  localparam int CFG_ADDR_W = fir_pkg::CFG_ADDR_W;
  localparam int IN_BITS    = fir_pkg::IN_BITS;
  localparam int IN_DATA_W  = fir_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = fir_pkg::OUT_DATA_W;
  localparam logic [TCOUNT_W-1:0] TCOUNT_RST = fir_pkg::TCOUNT_RST;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = fir_pkg::SHIFT_RST;
  localparam logic OP_SAMPLE     = fir_pkg::OP_SAMPLE;
  localparam logic OP_COEF       = fir_pkg::OP_COEF;
  localparam logic REG_TAP_COUNT = fir_pkg::REG_TAP_COUNT;
  localparam logic REG_OUT_SHIFT = fir_pkg::REG_OUT_SHIFT;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_BEATS = 560;
  localparam int HOLD_CYCLES = 3000;
  localparam int PRESSURE_BEATS = 6;
  localparam int IDLE_GUARD = 8;
  localparam int TAIL_CYCLES = TAPS + 16;
  localparam int DIR_ROWS = 25;

  localparam logic [CFG_ADDR_W-1:0] TAP_COUNT_ADDR = CFG_ADDR_W'(4 * REG_TAP_COUNT);
  localparam logic [CFG_ADDR_W-1:0] SHIFT_ADDR = CFG_ADDR_W'(4 * REG_OUT_SHIFT);

  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } fir_result_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       op;
    logic signed [SAMPLE_W-1:0] smp;
    logic [ADDR_W-1:0]          idx;
    logic signed [SAMPLE_W-1:0] val;
    logic [CFG_ADDR_W-1:0]      addr;
    logic [CFG_DATA_W-1:0]      wdata;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] want_filtered;
    logic                       want_sat;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic signed [SAMPLE_W-1:0] sample_hist [TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [TAPS];
  int                         hist_ptr;
  logic [TCOUNT_W-1:0]        cfg_taps;
  logic [SHIFT_W-1:0]         cfg_shift;
  fir_result_t                expected_results [$];
  fir_result_t                rx_want;

  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned cycle_count = 0;
  int          errors = 0;
  int          beats_sent = 0;
  int          sample_beats = 0;
  int          coef_beats = 0;
  int          results_checked = 0;
  int          sat_expected = 0;
  int          cfg_writes = 0;

  // Columns: kind, op, sample, tap index, tap value, address, write data,
  // typed expectation, expected filtered, expected saturated.
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_BEAT, OP_SAMPLE, 16'sh7fff, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh8000, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, TAP_COUNT_ADDR, 32'd1, 1'b0, 16'sd0, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, SHIFT_ADDR, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_COEF, 16'sd0, 10'd0, 16'sh7fff, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh7fff, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sh7fff, 1'b1},
    '{ROW_BEAT, OP_SAMPLE, 16'sh8000, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sh8000, 1'b1},
    '{ROW_BEAT, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sd1, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sh7fff, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, -16'sd1, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, -16'sd32767, 1'b0},
    '{ROW_BEAT, OP_COEF, 16'sd0, 10'd1023, 16'sh8000, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_COEF, 16'sd0, 10'd0, 16'sh8000, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, SHIFT_ADDR, 32'd31, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh8000, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh7fff, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, -16'sd1, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, TAP_COUNT_ADDR, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh7fff, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b1, -16'sd1, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, TAP_COUNT_ADDR, 32'd2047, 1'b0, 16'sd0, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, SHIFT_ADDR, 32'd15, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sd12345, 10'h3ff, 16'sh5555, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sh8000, 10'h2aa, 16'shaaaa, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_CFG, OP_SAMPLE, 16'sd0, 10'd0, 16'sd0, TAP_COUNT_ADDR, 32'd4, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_COEF, 16'sd0, 10'd1, 16'sd16384, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_COEF, 16'sd0, 10'd3, 16'sh7fff, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0},
    '{ROW_BEAT, OP_SAMPLE, 16'sd1000, 10'd0, 16'sd0, 3'd0, 32'd0, 1'b0, 16'sd0, 1'b0}
  };

  fir_convolution_filter dut (.*);

  always #4 clk = ~clk;

  function automatic fir_result_t filter_sample(input logic signed [SAMPLE_W-1:0] smp);
    int                       n;
    int                       j;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    fir_result_t              res;
    n = (cfg_taps == 0) ? 1 : (cfg_taps > TAPS) ? TAPS : int'(cfg_taps);
    if (hist_ptr >= n) hist_ptr = n - 1;
    sample_hist[hist_ptr] = smp;
    acc = '0;
    for (int k = 0; k < n; k++) begin
      j = hist_ptr + k;
      if (j >= n) j -= n;
      prod = coef_mem[k] * sample_hist[j];
      acc = acc + prod;
    end
    shifted = acc >>> cfg_shift;
    res.saturated = 1'b1;
    if (shifted > 40'sd32767) begin
      res.filtered = 16'sh7fff;
    end else if (shifted < -40'sd32768) begin
      res.filtered = 16'sh8000;
    end else begin
      res.filtered = shifted[SAMPLE_W-1:0];
      res.saturated = 1'b0;
    end
    hist_ptr = (hist_ptr == 0) ? n - 1 : hist_ptr - 1;
    return res;
  endfunction

  function automatic stim_row_t random_beat(input logic op, input int span);
    stim_row_t b;
    b.kind = ROW_BEAT;
    b.op = op;
    b.smp = SAMPLE_W'($urandom);
    b.idx = ADDR_W'($urandom);
    b.val = SAMPLE_W'($urandom);
    b.addr = '0;
    b.wdata = '0;
    b.typed = 1'b0;
    b.want_filtered = '0;
    b.want_sat = 1'b0;
    if ($urandom_range(7) == 0) begin
      b.smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      b.val = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    end
    if (op == OP_COEF && $urandom_range(3) != 0) b.idx = ADDR_W'($urandom_range(span - 1));
    return b;
  endfunction

  task automatic send_beat(input stim_row_t b);
    fir_result_t res;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.op;
    in_tdata <= {{(IN_DATA_W - IN_BITS){1'b0}}, b.val, b.idx, b.smp};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (b.op == OP_COEF) begin
      coef_mem[b.idx] = b.val;
      coef_beats++;
    end else begin
      res = filter_sample(b.smp);
      if (b.typed) begin
        res.filtered = b.want_filtered;
        res.saturated = b.want_sat;
      end
      sat_expected += res.saturated;
      expected_results.push_back(res);
      sample_beats++;
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    logic [CFG_DATA_W-1:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      if (addr == TAP_COUNT_ADDR) cfg_taps = data[TCOUNT_W-1:0];
      else if (addr == SHIFT_ADDR) cfg_shift = data[SHIFT_W-1:0];
      cfg_writes++;
    end else begin
      want = (addr == TAP_COUNT_ADDR) ? CFG_DATA_W'(cfg_taps) : CFG_DATA_W'(cfg_shift);
      if (cfg_prdata !== want) begin
        $display("%0t: register at 0x%0h expected 0x%0h got 0x%0h", $time, addr, want,
                 cfg_prdata);
        errors++;
      end
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_segment();
    logic [TCOUNT_W-1:0]   taps;
    logic [SHIFT_W-1:0]    shift;
    logic [CFG_DATA_W-1:0] word;
    int                    span;
    int                    n_coef;
    int                    n_samp;
    case ($urandom_range(7))
      0: taps = TCOUNT_W'($urandom_range(1));
      1: taps = TCOUNT_W'($urandom_range(1024, 2047));
      2: taps = TCOUNT_W'($urandom_range(25, 200));
      default: taps = TCOUNT_W'($urandom_range(1, 24));
    endcase
    case ($urandom_range(3))
      0: shift = '0;
      1: shift = '1;
      2: shift = SHIFT_W'($urandom_range(10, 20));
      default: shift = SHIFT_W'($urandom);
    endcase
    settle();
    word = $urandom;
    word[TCOUNT_W-1:0] = taps;
    cfg_access(1'b1, TAP_COUNT_ADDR, word);
    cfg_access(1'b0, TAP_COUNT_ADDR, '0);
    word = $urandom;
    word[SHIFT_W-1:0] = shift;
    cfg_access(1'b1, SHIFT_ADDR, word);
    cfg_access(1'b0, SHIFT_ADDR, '0);
    span = (taps == 0) ? 1 : (taps > TAPS) ? TAPS : int'(taps);
    n_coef = $urandom_range(1, (span < 12) ? span : 12);
    n_samp = (span > 200) ? $urandom_range(2, 3) : $urandom_range(8, 20);
    repeat (n_coef) send_beat(random_beat(OP_COEF, span));
    repeat (n_samp) begin
      if ($urandom_range(9) == 0) send_beat(random_beat(OP_COEF, span));
      send_beat(random_beat(OP_SAMPLE, span));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, filtered %0d saturated %0b", $time,
                 $signed(out_tdata[SAMPLE_W-1:0]), out_tuser);
        errors++;
      end else begin
        rx_want = expected_results.pop_front();
        results_checked++;
        if ($signed(out_tdata[SAMPLE_W-1:0]) !== rx_want.filtered) begin
          $display("%0t: filtered expected %0d got %0d", $time, rx_want.filtered,
                   $signed(out_tdata[SAMPLE_W-1:0]));
          errors++;
        end
        if (out_tuser !== rx_want.saturated) begin
          $display("%0t: saturated expected %0b got %0b", $time, rx_want.saturated, out_tuser);
          errors++;
        end
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int dir_beats;
    foreach (sample_hist[i]) begin
      sample_hist[i] = '0;
      coef_mem[i] = '0;
    end
    hist_ptr = 0;
    cfg_taps = TCOUNT_RST;
    cfg_shift = SHIFT_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, TAP_COUNT_ADDR, '0);
    cfg_access(1'b0, SHIFT_ADDR, '0);

    send_gap_pct = 37;
    recv_stall_pct = 53;
    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CFG) begin
        settle();
        cfg_access(1'b1, dir_table[r].addr, dir_table[r].wdata);
        cfg_access(1'b0, dir_table[r].addr, '0);
      end else begin
        send_beat(dir_table[r]);
      end
    end
    dir_beats = beats_sent;

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 37 : (ph == 1) ? 53 : 0;
      recv_stall_pct = (ph == 0) ? 53 : (ph == 1) ? 37 : 0;
      if (ph == 2) begin
        settle();
        hold_go = 1'b1;
        repeat (PRESSURE_BEATS) send_beat(random_beat(OP_SAMPLE, 1));
      end
      while (beats_sent - dir_beats < (ph + 1) * RANDOM_BEATS / 3) run_segment();
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Run covered %0d sample beats and %0d coefficient beats, %0d results checked.",
             sample_beats, coef_beats, results_checked);
    $display("%0d results clipped, %0d register writes, one %0d-cycle output hold.",
             sat_expected, cfg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
